### src/okvt_pkg.sv
package okvt_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [2:0] CMD_CONTAINS = 3'd0;
  localparam logic [2:0] CMD_GET      = 3'd1;
  localparam logic [2:0] CMD_SET      = 3'd2;
  localparam logic [2:0] CMD_POP      = 3'd3;
  localparam logic [2:0] CMD_POPITEM  = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic        upd_val;
    logic        append;
    logic        shift;
    logic        pick_last;
    logic [63:0] key;
    logic [63:0] value;
  } cell_ctl_t;

endpackage

### src/okvt_intf.sv
interface okvt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [63:0] key;
  logic signed [63:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

interface okvt_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [63:0] value_out;
  logic signed [63:0] key_out;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output found, output value_out, output key_out,
                  output status, output entry_count, input ready);
  modport sink (input valid, input found, input value_out, input key_out,
                input status, input entry_count, output ready);
endinterface

### src/ordered_key_value_table.sv
// Ordered key/value table with exact-match lookup, kept in insertion order.
// in_ch carries one command item (cmd, key, value); out_ch returns exactly one
// result item per command (found, value_out, key_out, status, entry_count).
// Both channels use valid/ready; an item moves when both are high.
// Storage is a row of CAPACITY cells; each compares its key against the
// command key in parallel, and a pop shifts the later cells down by one.
// The command is registered on acceptance, then compared and applied over the
// cell row in the execute state, where its result is registered once the output
// register is free. A new command is not taken until that state is left.
// in_ch.ready is high whenever no command is in progress, so a new command
// is taken while the previous result still waits in the output register.
// If out_ch stalls, the following command holds in its execute cycle until
// the output register frees up; nothing is dropped.
// Reset (rst, synchronous) empties the table and drops any pending result.
// Cell contents are not cleared; only entries below the count are read.
module ordered_key_value_table #(
  parameter int CAPACITY = okvt_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  okvt_in_if.sink   in_ch,
  okvt_out_if.source out_ch
);
  import okvt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t      state;
  state_t      state_next;
  logic [2:0]  cmd_r;
  logic [63:0] key_r;
  logic [63:0] val_r;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic        out_valid;
  logic        found;
  logic [63:0] value_out;
  logic [63:0] key_out;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  logic        found_next;
  logic [63:0] value_out_next;
  logic [63:0] key_out_next;
  logic [1:0]  status_next;

  logic        in_acc;
  logic        exec;
  logic        hit;
  logic        full;
  cell_ctl_t   ctl;

  logic [CAPACITY:0]   pre;
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-1:0] at_tail;
  logic [CAPACITY-1:0] at_last;
  logic [63:0] ck    [CAPACITY];
  logic [63:0] cv    [CAPACITY];
  logic [63:0] rdk   [CAPACITY];
  logic [63:0] rdv   [CAPACITY];
  logic [63:0] sk    [CAPACITY];
  logic [63:0] sv    [CAPACITY];
  logic [63:0] rd_key;
  logic [63:0] rd_val;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign exec        = (state == ST_EXEC) && (!out_valid || out_ch.ready);
  assign hit         = pre[CAPACITY];
  assign full        = (count == CW'(CAPACITY));
  assign pre[0]      = 1'b0;

  assign ctl.upd_val   = exec && (cmd_r == CMD_SET);
  assign ctl.append    = exec && (cmd_r == CMD_SET) && !hit && !full;
  assign ctl.shift     = exec && (cmd_r == CMD_POP);
  assign ctl.pick_last = (cmd_r == CMD_POPITEM);
  assign ctl.key       = key_r;
  assign ctl.value     = val_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign vld[i]     = (CW'(i) < count);
    assign at_tail[i] = (count == CW'(i));
    assign at_last[i] = (count == CW'(i + 1));

    okvt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .vld        (vld[i]),
      .at_tail    (at_tail[i]),
      .at_last    (at_last[i]),
      .nb_key     (ck[i]),
      .nb_val     (cv[i]),
      .prefix_in  (pre[i]),
      .prefix_out (pre[i+1]),
      .rd_key     (rdk[i]),
      .rd_val     (rdv[i]),
      .st_key     (sk[i]),
      .st_val     (sv[i])
    );

    if (i == CAPACITY - 1) begin : g_top
      assign ck[i] = '0;
      assign cv[i] = '0;
    end else begin : g_mid
      assign ck[i] = sk[i+1];
      assign cv[i] = sv[i+1];
    end
  end

  always_comb begin
    rd_key = '0;
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_key = rd_key | rdk[i];
      rd_val = rd_val | rdv[i];
    end
  end

  always_comb begin
    found_next     = 1'b0;
    value_out_next = '0;
    key_out_next   = '0;
    status_next    = STAT_OK;
    count_next     = count;
    unique case (cmd_r)
      CMD_CONTAINS: begin
        found_next = hit;
      end
      CMD_GET: begin
        found_next     = hit;
        value_out_next = rd_val;
        status_next    = hit ? STAT_OK : STAT_MISSING;
      end
      CMD_SET: begin
        found_next = hit;
        if (!hit) begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      CMD_POP: begin
        found_next     = hit;
        value_out_next = rd_val;
        status_next    = hit ? STAT_OK : STAT_MISSING;
        if (hit) begin
          count_next = count - CW'(1);
        end
      end
      CMD_POPITEM: begin
        if (count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          key_out_next   = rd_key;
          value_out_next = rd_val;
          count_next     = count - CW'(1);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_EXEC;
      ST_EXEC: if (exec) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec) begin
        count <= count_next;
      end
      out_valid <= exec || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.key;
      val_r <= in_ch.value;
    end
    if (exec) begin
      found       <= found_next;
      value_out   <= value_out_next;
      key_out     <= key_out_next;
      status      <= status_next;
      entry_count <= 5'(count_next);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.found       = found;
  assign out_ch.value_out   = value_out;
  assign out_ch.key_out     = key_out;
  assign out_ch.status      = status;
  assign out_ch.entry_count = entry_count;

endmodule

### src/okvt_cell.sv
module okvt_cell (
  input  logic                  clk,
  input  okvt_pkg::cell_ctl_t   ctl,
  input  logic                  vld,
  input  logic                  at_tail,
  input  logic                  at_last,
  input  logic [63:0]           nb_key,
  input  logic [63:0]           nb_val,
  input  logic                  prefix_in,
  output logic                  prefix_out,
  output logic [63:0]           rd_key,
  output logic [63:0]           rd_val,
  output logic [63:0]           st_key,
  output logic [63:0]           st_val
);
  import okvt_pkg::*;

  logic [63:0] key_q;
  logic [63:0] val_q;
  logic        match;
  logic        pick;

  assign match      = vld && (key_q == ctl.key);
  assign prefix_out = prefix_in | match;
  assign pick       = ctl.pick_last ? at_last : match;
  assign rd_key     = pick ? key_q : '0;
  assign rd_val     = pick ? val_q : '0;
  assign st_key     = key_q;
  assign st_val     = val_q;

  always_ff @(posedge clk) begin
    priority if (ctl.upd_val && match) begin
      val_q <= ctl.value;
    end else if (ctl.append && at_tail) begin
      key_q <= ctl.key;
      val_q <= ctl.value;
    end else if (ctl.shift && prefix_out) begin
      // close the gap: take the entry above
      key_q <= nb_key;
      val_q <= nb_val;
    end else begin
      // hold
      key_q <= key_q;
      val_q <= val_q;
    end
  end

endmodule

### src/okvt_checker.sv
module okvt_checker #(
  parameter int CAPACITY = okvt_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] key_out,
  input logic [1:0]  status,
  input logic [4:0]  entry_count
);
  import okvt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY >= 31) || (entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_EMPTY) |-> (entry_count == 5'd0) && (key_out == '0))
    else $error("empty-table result carries data");

  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ordered_key_value_table okvt_checker #(.CAPACITY(CAPACITY)) u_okvt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .key_out     (out_ch.key_out),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count)
);
